// ----- src/url_byte_class_statistics_defines.svh -----
// Assertion macros shared by the verification code of url_byte_class_statistics.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef URL_BYTE_CLASS_STATISTICS_DEFINES_SVH
`define URL_BYTE_CLASS_STATISTICS_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UBCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubcs check failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define UBCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubcs check failed one cycle later");

`endif

// ----- src/ubcs_pkg.sv -----
// Package for url_byte_class_statistics: commands, result kinds, character constants,
// counter indexes and the classified item that travels through the queue.
// No dependencies.
package ubcs_pkg;

    localparam int DEFAULT_COUNT_BITS = 16;
    localparam int FIELD_W            = 16;
    localparam int BYTE_W             = 8;
    localparam int NUM_BINS           = 256;
    localparam int NUM_CNT            = 8;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QPTR_W             = $clog2(QUEUE_DEPTH);

    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TUSER_W = 2;
    localparam int M_TDATA_W = BYTE_W + FIELD_W + NUM_CNT * FIELD_W;

    localparam int CNT_LEN        = 0;
    localparam int CNT_DOT        = 1;
    localparam int CNT_DASH       = 2;
    localparam int CNT_UNDERSCORE = 3;
    localparam int CNT_TILDE      = 4;
    localparam int CNT_DIGIT      = 5;
    localparam int CNT_LETTER     = 6;
    localparam int CNT_SPECIAL    = 7;

    localparam logic [BYTE_W-1:0] CHAR_DOT        = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_DASH       = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_TILDE      = 8'h7E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE       = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_LOW_A      = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOW_Z      = 8'h7A;
    localparam logic [BYTE_W-1:0] CHAR_UP_A       = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z       = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET     = 8'h20;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_TOTALS = 2'd1,
        KIND_BIN    = 2'd2
    } kind_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [BYTE_W-1:0]  addr;
        logic [BYTE_W-1:0]  lowered;
        logic [NUM_CNT-1:0] inc;
    } item_t;

endpackage

// ----- src/ubcs_fifo.sv -----
// Short queue of classified items between the front and back parts.
// Depends on ubcs_pkg.
module ubcs_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  ubcs_pkg::item_t push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output ubcs_pkg::item_t pop_item,
    input  logic            pop_ready
);

    ubcs_pkg::item_t                   slot_reg [ubcs_pkg::QUEUE_DEPTH];
    logic [ubcs_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ubcs_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [ubcs_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ubcs_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [ubcs_pkg::QPTR_W:0]         fill_reg;
    logic [ubcs_pkg::QPTR_W:0]         fill_next;
    logic                              push_fire;
    logic                              pop_fire;

    assign push_ready = (fill_reg != (ubcs_pkg::QPTR_W + 1)'(ubcs_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_fire && !pop_fire)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- src/ubcs_front.sv -----
// Front part: accepts commands from the input stream and classifies data bytes.
// Depends on ubcs_pkg.
module ubcs_front (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ubcs_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // cmd
    input  logic [ubcs_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // data_byte, bin_index
    output logic                              push_valid,
    output ubcs_pkg::item_t                   push_item,
    input  logic                              push_ready
);

    ubcs_pkg::cmd_t                cmd;
    logic [ubcs_pkg::BYTE_W-1:0]   data_byte;
    logic [ubcs_pkg::BYTE_W-1:0]   bin_index;
    logic                          is_digit;
    logic                          is_upper;
    logic                          is_lower;

    assign cmd       = ubcs_pkg::cmd_t'(s_axis_tuser);
    assign data_byte = s_axis_tdata[ubcs_pkg::BYTE_W-1:0];
    assign bin_index = s_axis_tdata[2*ubcs_pkg::BYTE_W-1:ubcs_pkg::BYTE_W];

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

    always_comb
    begin
        is_digit = (data_byte >= ubcs_pkg::CHAR_ZERO) && (data_byte <= ubcs_pkg::CHAR_NINE);
        is_upper = (data_byte >= ubcs_pkg::CHAR_UP_A) && (data_byte <= ubcs_pkg::CHAR_UP_Z);
        is_lower = (data_byte >= ubcs_pkg::CHAR_LOW_A) && (data_byte <= ubcs_pkg::CHAR_LOW_Z);

        push_item.cmd     = cmd;
        push_item.addr    = (cmd == ubcs_pkg::CMD_READ) ? bin_index : data_byte;
        push_item.lowered = is_upper ? data_byte + ubcs_pkg::CASE_OFFSET : data_byte;

        push_item.inc                           = '0;
        push_item.inc[ubcs_pkg::CNT_LEN]        = 1'b1;
        push_item.inc[ubcs_pkg::CNT_DOT]        = (data_byte == ubcs_pkg::CHAR_DOT);
        push_item.inc[ubcs_pkg::CNT_DASH]       = (data_byte == ubcs_pkg::CHAR_DASH);
        push_item.inc[ubcs_pkg::CNT_UNDERSCORE] = (data_byte == ubcs_pkg::CHAR_UNDERSCORE);
        push_item.inc[ubcs_pkg::CNT_TILDE]      = (data_byte == ubcs_pkg::CHAR_TILDE);
        push_item.inc[ubcs_pkg::CNT_DIGIT]      = is_digit;
        push_item.inc[ubcs_pkg::CNT_LETTER]     = is_upper || is_lower;
        push_item.inc[ubcs_pkg::CNT_SPECIAL]    = !is_digit && !is_upper && !is_lower;
    end

endmodule

// ----- src/ubcs_back.sv -----
// Back part: histogram read-modify-write, class counters and the output register.
// Depends on ubcs_pkg.
module ubcs_back #(
    parameter int COUNT_BITS = ubcs_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    input  ubcs_pkg::item_t                   pop_item,
    output logic                              pop_ready,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ubcs_pkg::M_TUSER_W-1:0]    m_axis_tuser,  // kind
    output logic [ubcs_pkg::M_TDATA_W-1:0]    m_axis_tdata   // lowered_byte, byte_count,
                                                             // total_length, dot_count,
                                                             // dash_count, underscore_count,
                                                             // tilde_count, digit_count,
                                                             // letter_count, special_count
);

    localparam int FW = ubcs_pkg::FIELD_W;
    localparam int BW = ubcs_pkg::BYTE_W;

    logic [COUNT_BITS-1:0]          hist_mem [ubcs_pkg::NUM_BINS];
    logic [COUNT_BITS-1:0]          rd_data_reg;
    logic [ubcs_pkg::NUM_BINS-1:0]  hist_vld_reg;
    logic [ubcs_pkg::NUM_BINS-1:0]  hist_vld_next;

    logic                           b_valid_reg;
    logic                           b_valid_next;
    ubcs_pkg::item_t                b_item_reg;
    logic                           fwd_en_reg;
    logic                           fwd_en_next;
    logic [BW-1:0]                  fwd_addr_reg;
    logic [COUNT_BITS-1:0]          fwd_val_reg;

    logic [COUNT_BITS-1:0]          cnt_reg  [ubcs_pkg::NUM_CNT];
    logic [COUNT_BITS-1:0]          cnt_next [ubcs_pkg::NUM_CNT];

    logic                           out_valid_reg;
    logic                           out_valid_next;
    ubcs_pkg::kind_t                out_kind_reg;
    ubcs_pkg::kind_t                out_kind_next;
    logic [ubcs_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [ubcs_pkg::M_TDATA_W-1:0] out_data_next;

    logic                           b_is_start;
    logic                           out_free;
    logic                           b_fire;
    logic                           a_fire;
    logic                           wr_en;
    logic [COUNT_BITS-1:0]          hist_old;
    logic [COUNT_BITS-1:0]          hist_new;
    logic [FW-1:0]                  field_count;

    assign b_is_start = (b_item_reg.cmd == ubcs_pkg::CMD_START);
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign b_fire     = b_valid_reg && (b_is_start || out_free);
    assign pop_ready  = !b_valid_reg || b_fire;
    assign a_fire     = pop_valid && pop_ready;
    assign wr_en      = b_fire && (b_item_reg.cmd == ubcs_pkg::CMD_DATA);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == b_item_reg.addr))
        begin
            hist_old = fwd_val_reg;
        end
        else if (hist_vld_reg[b_item_reg.addr])
        begin
            hist_old = rd_data_reg;
        end
        else
        begin
            hist_old = '0;
        end
        hist_new = (&hist_old) ? hist_old : hist_old + 1'b1;

        for (int i = 0; i < ubcs_pkg::NUM_CNT; i++)
        begin
            if (wr_en && b_item_reg.inc[i] && !(&cnt_reg[i]))
            begin
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end
            else
            begin
                cnt_next[i] = cnt_reg[i];
            end
        end

        hist_vld_next = hist_vld_reg;
        if (b_fire && b_is_start)
        begin
            hist_vld_next = '0;
        end
        else if (wr_en)
        begin
            hist_vld_next[b_item_reg.addr] = 1'b1;
        end

        b_valid_next = a_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);
        fwd_en_next  = a_fire ? wr_en : fwd_en_reg;

        out_kind_next = ubcs_pkg::KIND_BYTE;
        field_count   = '0;
        out_data_next = '0;
        case (b_item_reg.cmd)
            ubcs_pkg::CMD_DATA:
            begin
                out_kind_next             = ubcs_pkg::KIND_BYTE;
                field_count               = FW'(hist_new);
                out_data_next[BW-1:0]     = b_item_reg.lowered;
            end
            ubcs_pkg::CMD_FINISH:
            begin
                out_kind_next = ubcs_pkg::KIND_TOTALS;
            end
            ubcs_pkg::CMD_READ:
            begin
                out_kind_next = ubcs_pkg::KIND_BIN;
                field_count   = FW'(hist_old);
            end
            default:
            begin
                out_kind_next = ubcs_pkg::KIND_BYTE;
            end
        endcase
        out_data_next[BW +: FW] = field_count;
        if (b_item_reg.cmd != ubcs_pkg::CMD_READ)
        begin
            for (int i = 0; i < ubcs_pkg::NUM_CNT; i++)
            begin
                out_data_next[BW + FW + i*FW +: FW] = FW'(cnt_next[i]);
            end
        end

        if (b_fire && !b_is_start)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[b_item_reg.addr] <= hist_new;
        end
        if (a_fire)
        begin
            rd_data_reg <= hist_mem[pop_item.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_item_reg   <= pop_item;
            fwd_addr_reg <= b_item_reg.addr;
            fwd_val_reg  <= hist_new;
        end
        if (b_fire && !b_is_start)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_vld_reg  <= '0;
            for (int i = 0; i < ubcs_pkg::NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            fwd_en_reg    <= fwd_en_next;
            out_valid_reg <= out_valid_next;
            hist_vld_reg  <= hist_vld_next;
            for (int i = 0; i < ubcs_pkg::NUM_CNT; i++)
            begin
                if (b_fire && b_is_start)
                begin
                    cnt_reg[i] <= '0;
                end
                else
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

endmodule

// ----- src/url_byte_class_statistics.sv -----
// Top level of url_byte_class_statistics: front classifier, item queue and back end.
// Depends on ubcs_pkg, ubcs_front, ubcs_fifo and ubcs_back.
//
//   Channel   Dir  tuser         tdata
//   s_axis    in   cmd           data_byte, bin_index
//   m_axis    out  kind          lowered_byte, byte_count, eight class totals
//
// One command is accepted per cycle and one result is delivered per cycle when the
// output is not stalled. An accepted command is written to the queue; taking it from
// the queue reads the histogram, and its result is then loaded into the output
// register, from which it is offered.
// The histogram read-modify-write forwards the previous write, so equal bytes in a row
// do not slow the stream. Reset and start clear the histogram at once through per-bin
// valid bits. A stalled output fills the four-entry queue before the input stalls.
module url_byte_class_statistics #(
    parameter int COUNT_BITS = ubcs_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ubcs_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // cmd
    input  logic [ubcs_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // data_byte, bin_index
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ubcs_pkg::M_TUSER_W-1:0]    m_axis_tuser,  // kind
    output logic [ubcs_pkg::M_TDATA_W-1:0]    m_axis_tdata   // lowered_byte, byte_count,
                                                             // total_length, dot_count,
                                                             // dash_count, underscore_count,
                                                             // tilde_count, digit_count,
                                                             // letter_count, special_count
);

    logic            push_valid;
    logic            push_ready;
    ubcs_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    ubcs_pkg::item_t pop_item;

    ubcs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_item     (push_item),
        .push_ready    (push_ready)
    );

    ubcs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    ubcs_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_item      (pop_item),
        .pop_ready     (pop_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- src/ubcs_checker.sv -----
// Port-level checks for url_byte_class_statistics, bound to the top level.
// Depends on ubcs_pkg and url_byte_class_statistics_defines.svh.
`include "url_byte_class_statistics_defines.svh"

module ubcs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [ubcs_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input  logic [ubcs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [ubcs_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    input  logic [ubcs_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    `UBCS_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `UBCS_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A bin read carries only the bin count, and a report carries only the totals.
    `UBCS_ASSERT_IMP(a_bin_read_fields, m_axis_tvalid && m_axis_tuser == ubcs_pkg::KIND_BIN, m_axis_tdata[ubcs_pkg::M_TDATA_W-1:24] == '0 && m_axis_tdata[7:0] == '0)
    `UBCS_ASSERT_IMP(a_totals_fields, m_axis_tvalid && m_axis_tuser == ubcs_pkg::KIND_TOTALS, m_axis_tdata[23:0] == '0)

    // A lowered byte is never an upper-case letter.
    `UBCS_ASSERT_IMP(a_lowered_case, m_axis_tvalid && m_axis_tuser == ubcs_pkg::KIND_BYTE, m_axis_tdata[7:0] < ubcs_pkg::CHAR_UP_A || m_axis_tdata[7:0] > ubcs_pkg::CHAR_UP_Z)

endmodule

bind url_byte_class_statistics ubcs_checker u_ubcs_checker (.*);
